/* rtl/kctt_pkg.sv */
`default_nettype none

package kctt_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned USED_W   = $clog2(CAPACITY + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ITEM_W   = 8;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned DUR_W    = 24;
  localparam int unsigned DT_W     = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned ENTRY_W  = ITEM_W + OWNER_W + DUR_W;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 2'd0,
    OP_SET   = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_UPDATED = 2'd1,
    ST_ADDED   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/kctt_in_if.sv */
`default_nettype none

interface kctt_in_if;
  import kctt_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [ITEM_W-1:0]  item_id;
  logic [OWNER_W-1:0] owner_id;
  logic [DUR_W-1:0]   duration;
  logic [DT_W-1:0]    elapsed;

  modport source (
    output valid, operation, item_id, owner_id, duration, elapsed,
    input  ready
  );

  modport sink (
    input  valid, operation, item_id, owner_id, duration, elapsed,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/kctt_out_if.sv */
`default_nettype none

interface kctt_out_if;
  import kctt_pkg::*;

  logic                valid;
  logic                ready;
  logic                active;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (
    output valid, active, status, entry_count,
    input  ready
  );

  modport sink (
    input  valid, active, status, entry_count,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/keyed_countdown_timer_table_unit.sv */
// keyed countdown timer table
// in_i carries one operation per transfer: query, set or elapsed-time tick,
// with the (item_id, owner_id) key, the duration to load and the elapsed
// time to subtract. out_o returns exactly one result per operation: the
// active flag, the set status and the entry count after the operation.
// a query, set or tick walks the live entries in order through the single
// entry memory, one entry per cycle, with a registered read port. a query or
// set stops at the first key match; a tick visits all live entries and
// writes the survivors back compacted behind the read pointer.
// one operation is in flight at a time; the next input transfer is taken
// as soon as the result sits in the output register, even while the
// receiver stalls it. if a second result is ready before the first is
// taken, the block holds in its final step until the output frees up.
// reset empties the table at once: the live-entry count goes to zero and no
// result is pending; the entry memory itself is not cleared.
`default_nettype none

module keyed_countdown_timer_table_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kctt_in_if.sink   in_i,
  kctt_out_if.source out_o
);
  import kctt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  kctt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kctt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (in_i.operation),
    .item_id_i     (in_i.item_id),
    .owner_id_i    (in_i.owner_id),
    .duration_i    (in_i.duration),
    .elapsed_i     (in_i.elapsed),
    .active_o      (out_o.active),
    .status_o      (out_o.status),
    .entry_count_o (out_o.entry_count)
  );

endmodule

`default_nettype wire

/* rtl/kctt_datapath.sv */
`default_nettype none

module kctt_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire kctt_pkg::dp_cmd_t                cmd_i,
  output      kctt_pkg::dp_sts_t                sts_o,
  input  wire logic [kctt_pkg::OP_W-1:0]        operation_i,
  input  wire logic [kctt_pkg::ITEM_W-1:0]      item_id_i,
  input  wire logic [kctt_pkg::OWNER_W-1:0]     owner_id_i,
  input  wire logic [kctt_pkg::DUR_W-1:0]       duration_i,
  input  wire logic [kctt_pkg::DT_W-1:0]        elapsed_i,
  output      logic                             active_o,
  output      logic [kctt_pkg::STATUS_W-1:0]    status_o,
  output      logic [kctt_pkg::COUNT_W-1:0]     entry_count_o
);
  import kctt_pkg::*;

  // entry memory: {item, owner, remaining}
  logic [ENTRY_W-1:0] mem_q [CAPACITY];
  logic [ENTRY_W-1:0] rdata_q;

  op_e                op_q;
  logic [ITEM_W-1:0]  item_q;
  logic [OWNER_W-1:0] owner_q;
  logic [DUR_W-1:0]   dur_q;
  logic [DT_W-1:0]    dt_q;

  logic [USED_W-1:0]  used_q, used_d;
  logic [USED_W-1:0]  rd_ptr_q;
  logic [USED_W-1:0]  wr_ptr_q;
  logic               rvalid_q;
  logic [IDX_W-1:0]   ridx_q;
  logic               found_q;
  logic [IDX_W-1:0]   fidx_q;
  logic               fact_q;

  logic                active_q;
  logic [STATUS_W-1:0] status_q;
  logic [COUNT_W-1:0]  count_q;

  logic [ITEM_W-1:0]  rd_item;
  logic [OWNER_W-1:0] rd_owner;
  logic [DUR_W-1:0]   rd_rem;
  logic               is_search, is_tick, more, hit, keep, issue, room;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  status_e            status_d;

  assign rd_item  = rdata_q[ENTRY_W-1 -: ITEM_W];
  assign rd_owner = rdata_q[DUR_W +: OWNER_W];
  assign rd_rem   = rdata_q[DUR_W-1:0];

  assign is_search = (op_q == OP_QUERY) || (op_q == OP_SET);
  assign is_tick   = (op_q == OP_TICK);
  assign more      = rd_ptr_q < used_q;
  assign room      = used_q < USED_W'(CAPACITY);
  assign hit       = rvalid_q && is_search && !found_q &&
                     (rd_item == item_q) && (rd_owner == owner_q);
  // saturating subtract leaves time only when remaining exceeds elapsed
  assign keep      = rvalid_q && is_tick && (rd_rem > DUR_W'(dt_q));
  assign issue     = cmd_i.scan && (is_search || is_tick) && more && !found_q && !hit;

  assign sts_o.scan_end = !rvalid_q && (!more || found_q || !(is_search || is_tick));

  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr_q[IDX_W-1:0];
    wdata = {rd_item, rd_owner, rd_rem - DUR_W'(dt_q)};
    if (cmd_i.scan && keep) begin
      we = 1'b1;
    end else if (cmd_i.finish && (op_q == OP_SET)) begin
      wdata = {item_q, owner_q, dur_q};
      if (found_q) begin
        we    = 1'b1;
        waddr = fidx_q;
      end else if (room) begin
        we    = 1'b1;
        waddr = used_q[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    used_d   = used_q;
    status_d = ST_DONE;
    case (op_q)
      OP_SET: begin
        if (found_q) begin
          status_d = ST_UPDATED;
        end else if (room) begin
          status_d = ST_ADDED;
          used_d   = used_q + USED_W'(1);
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_TICK: begin
        used_d = wr_ptr_q;
      end
      default: begin
        used_d = used_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_ptr_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rvalid_q <= issue;
      if (cmd_i.load) begin
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (issue) begin
          rd_ptr_q <= rd_ptr_q + USED_W'(1);
        end
        if (cmd_i.scan && keep) begin
          wr_ptr_q <= wr_ptr_q + USED_W'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(operation_i);
      item_q  <= item_id_i;
      owner_q <= owner_id_i;
      dur_q   <= duration_i;
      dt_q    <= elapsed_i;
    end
    if (issue) begin
      ridx_q <= rd_ptr_q[IDX_W-1:0];
    end
    if (hit) begin
      fidx_q <= ridx_q;
      fact_q <= (rd_rem != '0);
    end
    if (cmd_i.finish) begin
      active_q <= (op_q == OP_QUERY) && found_q && fact_q;
      status_q <= status_d;
      count_q  <= COUNT_W'(used_d);
    end
  end

  assign active_o      = active_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

`default_nettype wire

/* rtl/kctt_ctrl.sv */
`default_nettype none

module kctt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      kctt_pkg::dp_cmd_t cmd_o,
  input  wire kctt_pkg::dp_sts_t sts_i
);
  import kctt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.finish = (state_q == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_end) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* test/keyed_countdown_timer_table_unit_test.sv */
`default_nettype none

module keyed_countdown_timer_table_unit_test;
  import kctt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned FILL_COUNT  = 300;
  localparam int unsigned RANDOM_OPS  = 250;
  localparam int unsigned END_WAIT    = 40;

  typedef struct packed {
    logic               active;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } timer_result_t;

  class timer_table_tracker;
    logic [ITEM_W-1:0]  key_item  [CAPACITY];
    logic [OWNER_W-1:0] key_owner [CAPACITY];
    logic [DUR_W-1:0]   time_left [CAPACITY];
    int                 used;
    int                 errors;
    int                 results_seen;
    timer_result_t      pending_results[$];

    function new();
      used = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function int lookup(logic [ITEM_W-1:0] item, logic [OWNER_W-1:0] owner);
      for (int i = 0; i < used; i++) begin
        if (key_item[i] == item && key_owner[i] == owner) return i;
      end
      return -1;
    endfunction

    function void note_op(op_e op, logic [ITEM_W-1:0] item, logic [OWNER_W-1:0] owner,
                          logic [DUR_W-1:0] dur, logic [DT_W-1:0] dt);
      timer_result_t res;
      int idx;
      int kept;
      logic [DUR_W-1:0] left;
      res.active = 1'b0;
      res.status = ST_DONE;
      case (op)
        OP_QUERY: begin
          idx = lookup(item, owner);
          if (idx >= 0 && time_left[idx] != '0) res.active = 1'b1;
        end
        OP_SET: begin
          idx = lookup(item, owner);
          if (idx >= 0) begin
            time_left[idx] = dur;
            res.status = ST_UPDATED;
          end else if (used < CAPACITY) begin
            key_item[used] = item;
            key_owner[used] = owner;
            time_left[used] = dur;
            used++;
            res.status = ST_ADDED;
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_TICK: begin
          kept = 0;
          for (int i = 0; i < used; i++) begin
            left = time_left[i];
            left = (left > DUR_W'(dt)) ? left - DUR_W'(dt) : '0;
            if (left != '0) begin
              key_item[kept] = key_item[i];
              key_owner[kept] = key_owner[i];
              time_left[kept] = left;
              kept++;
            end
          end
          used = kept;
        end
        default: ;
      endcase
      res.count = COUNT_W'(used);
      pending_results.push_back(res);
    endfunction

    task report(string what);
      $display("result %0d: %s", results_seen, what);
      errors++;
    endtask

    task check_result(logic active, logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no operation outstanding");
      end else begin
        want = pending_results.pop_front();
        if (active !== want.active)
          report($sformatf("active %0d, expected %0d", active, want.active));
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (count !== want.count)
          report($sformatf("entry_count %0d, expected %0d", count, want.count));
      end
      results_seen++;
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kctt_in_if  in_if ();
  kctt_out_if out_if ();

  keyed_countdown_timer_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  timer_table_tracker tracker = new();

  int          burst_left = 0;
  int          cycle_count = 0;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [5:0]  stall_phase = '0;

  logic [ITEM_W-1:0]  item_pool [6] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
  logic [OWNER_W-1:0] owner_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8000};

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OP_QUERY;
    in_if.item_id = '0;
    in_if.owner_id = '0;
    in_if.duration = '0;
    in_if.elapsed = '0;
    out_if.ready = 1'b0;
  end

  // receiver stall pattern, reloaded each time the 6-bit phase counter wraps
  always @(negedge clk_i) begin
    if (stall_phase == '0) begin
      if ($urandom_range(0, 2) == 0) stall_mask = 16'hFFFF;
      else stall_mask = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
    end
    out_if.ready <= stall_mask[stall_phase[3:0]];
    stall_phase <= stall_phase + 6'd1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      tracker.check_result(out_if.active, out_if.status, out_if.entry_count);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("keyed_countdown_timer_table_unit_test: FAIL");
    $finish;
  end

  task automatic send_op(input op_e op, input logic [ITEM_W-1:0] item,
                         input logic [OWNER_W-1:0] owner, input logic [DUR_W-1:0] dur,
                         input logic [DT_W-1:0] dt);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.item_id <= item;
    in_if.owner_id <= owner;
    in_if.duration <= dur;
    in_if.elapsed <= dt;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_op(op, item, owner, dur, dt);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic send_set(input logic [ITEM_W-1:0] item, input logic [OWNER_W-1:0] owner,
                          input logic [DUR_W-1:0] dur);
    send_op(OP_SET, item, owner, dur, DT_W'($urandom));
  endtask

  task automatic send_query(input logic [ITEM_W-1:0] item, input logic [OWNER_W-1:0] owner);
    send_op(OP_QUERY, item, owner, DUR_W'($urandom), DT_W'($urandom));
  endtask

  task automatic send_tick(input logic [DT_W-1:0] dt);
    send_op(OP_TICK, ITEM_W'($urandom), OWNER_W'($urandom), DUR_W'($urandom), dt);
  endtask

  task automatic send_random_op();
    int sel;
    logic [ITEM_W-1:0]  item;
    logic [OWNER_W-1:0] owner;
    logic [DUR_W-1:0]   dur;
    logic [DT_W-1:0]    dt;
    if ($urandom_range(0, 99) < 85) begin
      item = item_pool[$urandom_range(0, 5)];
      owner = owner_pool[$urandom_range(0, 3)];
    end else begin
      item = ITEM_W'($urandom);
      owner = OWNER_W'($urandom);
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) dur = '0;
    else if (sel == 1) dur = DUR_W'($urandom);
    else dur = DUR_W'($urandom_range(1, 3000));
    sel = $urandom_range(0, 9);
    if (sel == 0) dt = '0;
    else if (sel == 1) dt = DT_W'($urandom);
    else dt = DT_W'($urandom_range(0, 1500));
    sel = $urandom_range(0, 99);
    if (sel < 35) send_op(OP_QUERY, item, owner, dur, dt);
    else if (sel < 75) send_op(OP_SET, item, owner, dur, dt);
    else if (sel < 95) send_op(OP_TICK, item, owner, dur, dt);
    else send_op(OP_NONE, item, owner, dur, dt);
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every operation, zero duration, zero elapsed, missing keys
    send_query(8'h00, 16'h0000);
    send_tick(16'h0000);
    send_set(8'hFF, 16'hFFFF, 24'hFFFFFF);
    send_set(8'h00, 16'h0000, 24'h000000);
    send_set(8'h01, 16'hFFFF, 24'h000001);
    send_query(8'hFF, 16'hFFFF);
    send_query(8'h00, 16'h0000);
    send_query(8'h00, 16'hFFFF);
    send_set(8'hFF, 16'hFFFF, 24'h000005);
    send_op(OP_NONE, 8'h3C, 16'hC3C3, 24'h0F0F0F, 16'hF0F0);
    send_tick(16'h0000);
    send_query(8'h00, 16'h0000);
    send_tick(16'h0001);
    send_query(8'h01, 16'hFFFF);
    send_set(8'hFF, 16'hFFFF, 24'hFFFFFF);
    send_set(8'hFF, 16'h0000, 24'h555555);
    send_set(8'hAA, 16'h5555, 24'hAAAAAA);
    send_query(8'hFF, 16'h0000);
    send_tick(16'hFFFF);
    send_query(8'hFF, 16'hFFFF);
    send_op(OP_NONE, 8'hFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    send_tick(16'hFFFF);

    drain_results();

    // fill a large part of the table, then hit it with new and known keys
    k = 0;
    while (tracker.used < FILL_COUNT) begin
      send_set(8'(k), 16'hC000 + 16'(k >> 8), DUR_W'($urandom_range(0, 1000)));
      k++;
    end
    send_set(8'h12, 16'h3456, 24'h000100);
    send_set(8'hFF, 16'hFFFF, 24'h000200);
    send_set(8'h00, 16'hC000, 24'h000300);
    send_query(8'h00, 16'hC000);
    send_set(8'hEE, 16'h7777, 24'hFFFFFF);
    send_op(OP_NONE, 8'h00, 16'h0000, 24'h000000, 16'h0000);
    send_tick(16'd500);
    send_tick(16'hFFFF);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 2) drain_results();
      send_random_op();
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    if (tracker.errors == 0) $display("keyed_countdown_timer_table_unit_test: PASS");
    else $display("keyed_countdown_timer_table_unit_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
